// File: hw/rtl/fpa_pkg.sv
// Package with the command codes and pipeline item types of the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

   localparam int FIELD_W = 32;  // width of operand and result fields
   localparam int NUM_W   = 62;  // widest scaled dividend magnitude
   localparam int PROD_W  = 64;  // full signed product

   typedef enum logic [3:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_CMP      = 4'd4,
      CMD_MIN      = 4'd5,
      CMD_MAX      = 4'd6,
      CMD_INC      = 4'd7,
      CMD_DEC      = 4'd8,
      CMD_TO_INT   = 4'd9,
      CMD_FROM_INT = 4'd10
   } cmd_type;

   // One request on its way through the divider chain.
   typedef struct packed {
      logic                valid;
      cmd_type             cmd;
      logic [FIELD_W-1:0]  res;     // result of the commands resolved in the input stage
      logic                lt;
      logic                eq;
      logic                gt;
      logic                ov;
      logic                dz;
      logic                is_div;  // divide with a nonzero divisor
      logic                neg;     // sign of the quotient
      logic [PROD_W-1:0]   prod;
      logic [NUM_W-1:0]    num;
      logic [FIELD_W-1:0]  den;
      logic [FIELD_W-1:0]  rem;
      logic [NUM_W-1:0]    quot;
   } item_type;

   // One request after rounding, before saturation.
   typedef struct packed {
      logic                valid;
      cmd_type             cmd;
      logic [FIELD_W-1:0]  res;
      logic                lt;
      logic                eq;
      logic                gt;
      logic                ov;
      logic                dz;
      logic                is_div;
      logic                neg_div;
      logic                neg_mul;
      logic [PROD_W-1:0]   mmag;
      logic [NUM_W:0]      dmag;
   } fin_type;

endpackage

// File: hw/rtl/fpa_front.sv
// Input stage: the commands resolved here, the product and the divider operands.
`timescale 1ns / 1ps
module fpa_front #(
   parameter int W         = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [3:0]                    in_cmd,
   input  logic [fpa_pkg::FIELD_W-1:0]   in_a,
   input  logic [fpa_pkg::FIELD_W-1:0]   in_b,
   output fpa_pkg::item_type             item_out
);
   import fpa_pkg::*;

   localparam int SH = FIELD_W - W;
   localparam logic signed [63:0] MAXV = 64'sd1 <<< (W - 1);
   localparam logic signed [63:0] VMAX = MAXV - 64'sd1;
   localparam logic signed [63:0] VMIN = -MAXV;

   item_type item_ff, item_in;

   logic signed [FIELD_W-1:0] sa, sb;
   logic signed [63:0]        a64, b64, sum, dif, inc, dec, shl;
   logic [63:0]               amag, bmag;
   cmd_type                   cmd;

   function automatic logic signed [63:0] sat(input logic signed [63:0] v);
      if (v > VMAX)
         sat = VMAX;
      else if (v < VMIN)
         sat = VMIN;
      else
         sat = v;
   endfunction

   function automatic logic out_of_range(input logic signed [63:0] v);
      out_of_range = (v > VMAX) || (v < VMIN);
   endfunction

   always_comb begin
      cmd  = cmd_type'(in_cmd);
      sa   = $signed(in_a << SH) >>> SH;
      sb   = $signed(in_b << SH) >>> SH;
      a64  = 64'(sa);
      b64  = 64'(sb);
      sum  = a64 + b64;
      dif  = a64 - b64;
      inc  = a64 + 64'sd1;
      dec  = a64 - 64'sd1;
      shl  = a64 <<< FRAC_BITS;
      amag = (a64 < 0) ? 64'(-a64) : 64'(a64);
      bmag = (b64 < 0) ? 64'(-b64) : 64'(b64);

      item_in        = '0;
      item_in.valid  = in_valid;
      item_in.cmd    = cmd;
      item_in.prod   = 64'(sa * sb);
      item_in.num    = NUM_W'(amag << FRAC_BITS);
      item_in.den    = bmag[FIELD_W-1:0];
      item_in.neg    = sa[FIELD_W-1] ^ sb[FIELD_W-1];

      unique case (cmd)
         CMD_ADD: begin
            item_in.res = FIELD_W'(sat(sum));
            item_in.ov  = out_of_range(sum);
         end
         CMD_SUB: begin
            item_in.res = FIELD_W'(sat(dif));
            item_in.ov  = out_of_range(dif);
         end
         CMD_DIV: begin
            if (sb == 0) begin
               item_in.dz  = 1'b1;
               item_in.res = (sa > 0) ? FIELD_W'(VMAX) :
                             ((sa < 0) ? FIELD_W'(VMIN) : '0);
            end else begin
               item_in.is_div = 1'b1;
            end
         end
         CMD_CMP: begin
            item_in.lt = sa < sb;
            item_in.eq = sa == sb;
            item_in.gt = sa > sb;
         end
         CMD_MIN: item_in.res = (sa < sb) ? sa : sb;
         CMD_MAX: item_in.res = (sa > sb) ? sa : sb;
         CMD_INC: begin
            item_in.res = FIELD_W'(sat(inc));
            item_in.ov  = out_of_range(inc);
         end
         CMD_DEC: begin
            item_in.res = FIELD_W'(sat(dec));
            item_in.ov  = out_of_range(dec);
         end
         CMD_TO_INT: item_in.res = sa >>> FRAC_BITS;
         CMD_FROM_INT: begin
            item_in.res = FIELD_W'(sat(shl));
            item_in.ov  = out_of_range(shl);
         end
         default: item_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (en) begin
         item_ff <= item_in;
      end
   end

   assign item_out = item_ff;

endmodule

// File: hw/rtl/fpa_div_cell.sv
// One restoring-division cell: develops one quotient bit per request.
`timescale 1ns / 1ps
module fpa_div_cell #(
   parameter int NCELL = 40,
   parameter int IDX   = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  fpa_pkg::item_type  item_in_port,
   output fpa_pkg::item_type  item_out
);
   import fpa_pkg::*;

   localparam int BIT = NCELL - 1 - IDX;

   item_type          item_ff, item_in;
   logic [FIELD_W:0]  rem_sh, rem_sub;
   logic              qbit;

   always_comb begin
      rem_sh  = {item_in_port.rem, item_in_port.num[BIT]};
      rem_sub = rem_sh - {1'b0, item_in_port.den};
      qbit    = rem_sh >= {1'b0, item_in_port.den};
      item_in = item_in_port;
      item_in.rem  = qbit ? rem_sub[FIELD_W-1:0] : rem_sh[FIELD_W-1:0];
      item_in.quot = {item_in_port.quot[NUM_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (en) begin
         item_ff <= item_in;
      end
   end

   assign item_out = item_ff;

endmodule

// File: hw/rtl/fpa_back.sv
// Output stages: rounding, saturation and the response register.
`timescale 1ns / 1ps
module fpa_back #(
   parameter int W         = 32,
   parameter int FRAC_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  fpa_pkg::item_type            item_in_port,
   output logic                         out_valid,
   output logic [fpa_pkg::FIELD_W+4:0]  out_data
);
   import fpa_pkg::*;

   localparam logic [63:0] HALF  = (64'd1 << FRAC_BITS) >> 1;
   localparam logic [63:0] LIMP  = (64'd1 << (W - 1)) - 64'd1;
   localparam logic [63:0] LIMN  = 64'd1 << (W - 1);

   fin_type             fin_ff, fin_in;
   logic                valid_ff;
   logic [FIELD_W+4:0]  data_ff, data_in;
   logic [63:0]         pmag, lim, val;
   logic [FIELD_W-1:0]  res;
   logic                ov, rnd;

   always_comb begin
      pmag = item_in_port.prod[PROD_W-1] ? 64'(-item_in_port.prod) : item_in_port.prod;
      rnd  = {item_in_port.rem, 1'b0} >= {1'b0, item_in_port.den};
      fin_in         = '0;
      fin_in.valid   = item_in_port.valid;
      fin_in.cmd     = item_in_port.cmd;
      fin_in.res     = item_in_port.res;
      fin_in.lt      = item_in_port.lt;
      fin_in.eq      = item_in_port.eq;
      fin_in.gt      = item_in_port.gt;
      fin_in.ov      = item_in_port.ov;
      fin_in.dz      = item_in_port.dz;
      fin_in.is_div  = item_in_port.is_div;
      fin_in.neg_div = item_in_port.neg;
      fin_in.neg_mul = item_in_port.prod[PROD_W-1];
      fin_in.mmag    = (pmag + HALF) >> FRAC_BITS;
      fin_in.dmag    = {1'b0, item_in_port.quot} + (NUM_W+1)'(rnd);
   end

   always_comb begin
      res = fin_ff.res;
      ov  = fin_ff.ov;
      lim = '0;
      val = '0;
      if (fin_ff.cmd == CMD_MUL) begin
         lim = fin_ff.neg_mul ? LIMN : LIMP;
         ov  = fin_ff.mmag > lim;
         val = ov ? lim : fin_ff.mmag;
         res = fin_ff.neg_mul ? FIELD_W'(-val) : FIELD_W'(val);
      end else if (fin_ff.is_div) begin
         lim = fin_ff.neg_div ? LIMN : LIMP;
         ov  = 64'(fin_ff.dmag) > lim;
         val = ov ? lim : 64'(fin_ff.dmag);
         res = fin_ff.neg_div ? FIELD_W'(-val) : FIELD_W'(val);
      end
      data_in = {fin_ff.dz, ov, fin_ff.gt, fin_ff.eq, fin_ff.lt, res};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff.valid <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (en) begin
         fin_ff   <= fin_in;
         valid_ff <= fin_ff.valid;
         data_ff  <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hw/rtl/fixed_point_alu_top.sv
// Top level of the signed fixed-point ALU with its pipelined divider chain.
`timescale 1ns / 1ps
// The ALU takes one request per clock cycle while no response is held back
// and returns one response per request, in order, through one input stage,
// one divider cell per quotient bit (datapath width capped at 32), a
// rounding stage and the response register. The divider chain develops one
// quotient bit per cell; every command travels through the same stages so
// responses never reorder. The whole pipeline advances whenever the response
// register is empty or being taken, so a stalled response holds the input
// off only while it waits. Products and quotients round half away from
// zero; results that do not fit saturate and raise overflow, and a divide
// by zero saturates by the dividend's sign.
module fixed_point_alu_top #(
   parameter int FRAC_BITS  = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command [3:0], operand_a [35:4], operand_b [67:36], zero fill above
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_raw [31:0], a_less [32], a_equal [33], a_greater [34],
   // overflow [35], divide_by_zero [36], zero fill above
   output logic [39:0] rsp_tdata
);
   import fpa_pkg::*;

   localparam int W     = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
   localparam int NCELL = W + FRAC_BITS;

   logic                en;
   item_type            chain [0:NCELL];
   logic [FIELD_W+4:0]  rsp_data;

   // The pipeline moves when nothing is stuck in the response register.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   fpa_front #(.W(W), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_cmd   (req_tdata[3:0]),
      .in_a     (req_tdata[35:4]),
      .in_b     (req_tdata[67:36]),
      .item_out (chain[0])
   );

   // Each cell shifts in one dividend bit and emits one quotient bit.
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      fpa_div_cell #(.NCELL(NCELL), .IDX(i)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .en           (en),
         .item_in_port (chain[i]),
         .item_out     (chain[i+1])
      );
   end

   fpa_back #(.W(W), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .item_in_port (chain[NCELL]),
      .out_valid    (rsp_tvalid),
      .out_data     (rsp_data)
   );

   assign rsp_tdata = {3'b000, rsp_data};

`ifndef SYNTH
   // At most one ordering flag is set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[34:32]))
      else $error("compare flags not exclusive");

   // A compare response carries a zero result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[32] || rsp_tdata[33] || rsp_tdata[34]))
         |-> rsp_tdata[31:0] == 32'd0)
      else $error("compare response with nonzero result");

   // Divide by zero never reports overflow as well.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[36]) |-> !rsp_tdata[35])
      else $error("divide by zero with overflow");

   // Requests are refused only while a response is held back.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request refused without a stalled response");
`endif

endmodule

// File: verif/tb_fixed_point_alu_top.sv
// Self-checking testbench for the signed fixed-point ALU top level.
`timescale 1ns / 1ps
module tb_fixed_point_alu_top;
   import fpa_pkg::*;

   localparam int FRAC = 8;
   localparam int DW = 32;
   localparam int LATENCY = DW + FRAC + 3;
   localparam int NUM_RANDOM = 2000;
   localparam longint SAT_MAX = 64'sd2147483647;
   localparam longint SAT_MIN = -64'sd2147483648;

   // One ALU request as driven on req_tdata.
   typedef struct packed {
      logic [3:0]  cmd;
      logic [31:0] opa;
      logic [31:0] opb;
   } alu_req_type;

   // One expected response, packed from the top bit down as on rsp_tdata.
   typedef struct packed {
      logic        dz;
      logic        ov;
      logic        gt;
      logic        eq;
      logic        lt;
      logic [31:0] res;
   } alu_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   alu_req_type pending_reqs[$];
   alu_rsp_type expected_rsps[$];
   alu_req_type cur_req;
   bit          have_req = 1'b0;    // cur_req is on the bus and not yet taken
   int          idle_left = 0;
   int          stall_left = 0;
   int          mismatch_count = 0;
   int          rsp_count = 0;
   int          req_count = 0;
   bit          quiet_phase = 1'b0;  // no idling on either side near the end
   bit          hold_off = 1'b0;     // long receiver stall to fill the pipeline

   fixed_point_alu_top #(.FRAC_BITS(FRAC), .DATA_WIDTH(DW)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp a wide value to the signed 32-bit range and note whether it clipped.
   function automatic logic [31:0] clamp32(input longint v, inout logic ov);
      if (v > SAT_MAX) begin
         ov = 1'b1;
         return SAT_MAX[31:0];
      end
      if (v < SAT_MIN) begin
         ov = 1'b1;
         return SAT_MIN[31:0];
      end
      return v[31:0];
   endfunction

   // Computes the exact response of the ALU for one request. Products and
   // quotients are rounded half away from zero on their magnitudes.
   function automatic alu_rsp_type alu_result(input alu_req_type rq);
      alu_rsp_type r;
      longint      a, b, p, q;
      logic [63:0] m, num, den, rem;
      logic        ov;
      a = longint'(signed'(rq.opa));
      b = longint'(signed'(rq.opb));
      r = '0;
      ov = 1'b0;
      case (rq.cmd)
         CMD_ADD: r.res = clamp32(a + b, ov);
         CMD_SUB: r.res = clamp32(a - b, ov);
         CMD_MUL: begin
            p = a * b;
            m = (p < 0) ? -p : p;
            m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
            q = (p < 0) ? -longint'(m) : longint'(m);
            r.res = clamp32(q, ov);
         end
         CMD_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
               r.res = (a > 0) ? SAT_MAX[31:0] : ((a < 0) ? SAT_MIN[31:0] : 32'd0);
            end else begin
               num = ((a < 0) ? -a : a) << FRAC;
               den = (b < 0) ? -b : b;
               m = num / den;
               rem = num % den;
               if (rem >= den - rem) m = m + 1;
               q = ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
               r.res = clamp32(q, ov);
            end
         end
         CMD_CMP: begin
            r.lt = a < b;
            r.eq = a == b;
            r.gt = a > b;
         end
         CMD_MIN: r.res = (a < b) ? rq.opa : rq.opb;
         CMD_MAX: r.res = (a > b) ? rq.opa : rq.opb;
         CMD_INC: r.res = clamp32(a + 1, ov);
         CMD_DEC: r.res = clamp32(a - 1, ov);
         CMD_TO_INT: r.res = 32'(a >>> FRAC);
         CMD_FROM_INT: r.res = clamp32(a * (64'sd1 <<< FRAC), ov);
         default: r.res = '0;
      endcase
      r.ov = ov;
      return r;
   endfunction

   // Random operand biased toward the values that stress rounding and
   // saturation: extremes, small numbers and values near the range edges.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 1024) - 512;
         3: return 32'd0;
         4: return $urandom_range(0, 1) ? 32'($urandom_range(0, 8388607)) << 8
                                        : -(32'($urandom_range(0, 8388607)) << 8);
         5: return 32'($urandom) >>> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_req(input logic [3:0] cmd, input logic [31:0] a,
                            input logic [31:0] b);
      alu_req_type rq;
      rq.cmd = cmd;
      rq.opa = a;
      rq.opb = b;
      pending_reqs.push_back(rq);
   endtask

   // Driver: presents requests at the falling edge, with random idle bursts.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!have_req) begin
         if (idle_left > 0) begin
            idle_left--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
               idle_left = $urandom_range(1, 8) - 1;
               req_tvalid <= 1'b0;
            end else begin
               cur_req = pending_reqs.pop_front();
               have_req = 1'b1;
               req_tdata <= {4'd0, cur_req.opb, cur_req.opa, cur_req.cmd};
               req_tvalid <= 1'b1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // A request taken at this edge: record the response it must produce.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_rsps.push_back(alu_result(cur_req));
         req_count++;
         have_req = 1'b0;
      end
   end

   // Receiver ready: random stall bursts, plus one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: checks every accepted response against the oldest expectation.
   always @(posedge clock) begin
      alu_rsp_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[36:0];
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: response %h arrived with none expected", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"ERROR: response %0d: res %h/%h lt %b/%b eq %b/%b",
                            " gt %b/%b ov %b/%b dz %b/%b (exp/act)"},
                           rsp_count, want.res, got.res, want.lt, got.lt,
                           want.eq, got.eq, want.gt, got.gt, want.ov, got.ov,
                           want.dz, got.dz);
            end
         end
      end
   end

   // Long receiver stall, counted in cycles, while requests keep coming.
   initial begin : pressure
      int n;
      wait (req_count > 300);
      @(negedge clock);
      hold_off = 1'b1;
      for (n = 0; n < 3 * LATENCY; n++) @(negedge clock);
      hold_off = 1'b0;
   end

   // Stimulus: directed corner cases first, then random requests.
   initial begin : stimulus
      int i, c;
      for (i = 0; i < 7; i++) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_req(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
      queue_req(CMD_SUB, 32'h8000_0000, 32'h0000_0001);
      queue_req(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_req(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
      queue_req(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0080);   // negative half LSB rounds away
      queue_req(CMD_MUL, 32'h0000_0001, 32'h0000_0080);   // exact half LSB
      queue_req(CMD_DIV, 32'h0000_0100, 32'h0000_0000);
      queue_req(CMD_DIV, 32'hFFFF_FF00, 32'h0000_0000);
      queue_req(CMD_DIV, 32'h0000_0000, 32'h0000_0000);
      queue_req(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_req(CMD_DIV, 32'h0000_0001, 32'h0000_0200);   // tie in quotient
      queue_req(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_req(CMD_CMP, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_req(CMD_CMP, 32'h1234_5678, 32'h1234_5678);
      queue_req(CMD_CMP, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_req(CMD_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_req(CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_req(CMD_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_req(CMD_DEC, 32'h8000_0000, 32'hFFFF_FFFF);
      queue_req(CMD_TO_INT, 32'hFFFF_FFFF, 32'h0);
      queue_req(CMD_TO_INT, 32'h7FFF_FFFF, 32'h0);
      queue_req(CMD_FROM_INT, 32'h0080_0000, 32'h0);
      queue_req(CMD_FROM_INT, 32'hFF7F_FFFF, 32'h0);
      queue_req(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);     // unused command code

      for (i = 0; i < NUM_RANDOM; i++) begin
         c = $urandom_range(0, 15);
         if (c > 10 && $urandom_range(0, 3) != 0) c = $urandom_range(0, 10);
         queue_req(4'(c), pick_operand(), pick_operand());
         // Turn off idling for the tail of the run.
         if (i == NUM_RANDOM - 200) begin
            wait (pending_reqs.size() < 50);
            quiet_phase = 1'b1;
         end
      end

      wait (pending_reqs.size() == 0 && !have_req);
      wait (expected_rsps.size() == 0);
      for (i = 0; i < 2 * LATENCY; i++) @(posedge clock);
      $display("Checked %0d requests over all eleven commands and unused codes,", req_count);
      $display("%0d responses with random stalls and one long output hold-off.", rsp_count);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  expected_rsps.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #2_000_000;
      $display("Timeout waiting for responses");
      $display("Simulation FAILED");
      $finish;
   end
endmodule
